FILE: src/drc_pkg.sv
package drc_pkg;

	localparam int MaxBits     = 32;
	localparam int KeyW        = 32;
	localparam int HeightW     = 5;
	localparam int ActiveBitsW = 6;
	localparam int StackDepth  = 64;
	localparam int StackAw     = $clog2(StackDepth);
	localparam int SpW         = StackAw + 1;
	localparam int CfgAw       = 3;
	localparam int CfgDw       = 32;

	localparam logic CfgIdxActiveBits = 1'b0;
	localparam logic [ActiveBitsW-1:0] ActiveBitsReset = ActiveBitsW'(MaxBits);

	typedef struct packed {
		logic [KeyW-1:0] left_edge;
		logic [KeyW-1:0] right_edge;
	} query_t;

	typedef struct packed {
		logic [KeyW-1:0]    node_prefix;
		logic [HeightW-1:0] node_height;
		logic               is_empty;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [KeyW-1:0]    prefix;
		logic [HeightW-1:0] height;
	} node_t;

	typedef struct packed {
		logic               we;
		logic [StackAw-1:0] waddr;
		node_t              wdata;
		logic [StackAw-1:0] raddr;
	} stack_req_t;

endpackage

FILE: src/drc_stack_ram.sv
module drc_stack_ram (
	input  logic               clk,
	input  drc_pkg::stack_req_t req,
	output drc_pkg::node_t     rdata
);

	drc_pkg::node_t mem [drc_pkg::StackDepth];
	drc_pkg::node_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/drc_cfg.sv
module drc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [drc_pkg::CfgAw-1:0]          paddr,
	input  logic [drc_pkg::CfgDw-1:0]          pwdata,
	output logic [drc_pkg::CfgDw-1:0]          prdata,
	output logic                               pready,
	output logic [drc_pkg::ActiveBitsW-1:0]    active_bits
);

	logic [drc_pkg::ActiveBitsW-1:0] active_bits_q;
	logic                            sel_active_bits;

	assign sel_active_bits = (paddr[2] == drc_pkg::CfgIdxActiveBits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bits_q <= drc_pkg::ActiveBitsReset;
		end else if (psel && penable && pwrite && pready && sel_active_bits) begin
			active_bits_q <= pwdata[drc_pkg::ActiveBitsW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_active_bits) begin
			prdata = {{(drc_pkg::CfgDw - drc_pkg::ActiveBitsW){1'b0}}, active_bits_q};
		end
	end

	assign pready      = 1'b1;
	assign active_bits = active_bits_q;

endmodule

FILE: src/drc_walk.sv
module drc_walk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  drc_pkg::query_t                 query,
	input  logic [drc_pkg::ActiveBitsW-1:0] active_bits,
	output logic                            busy,
	output logic                            result_valid,
	output drc_pkg::result_t                result,
	output drc_pkg::stack_req_t             stack_req,
	input  drc_pkg::node_t                  stack_rdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FETCH,
		ST_FLUSH
	} state_t;

	state_t                          state_q;
	drc_pkg::node_t                  top_q;
	drc_pkg::node_t                  pend_q;
	logic                            pend_valid_q;
	logic [drc_pkg::KeyW-1:0]        lo_q;
	logic [drc_pkg::KeyW-1:0]        hi_q;
	logic [drc_pkg::SpW-1:0]         sp_q;
	logic                            res_valid_q;
	drc_pkg::result_t                res_q;

	logic [drc_pkg::ActiveBitsW-1:0] eff_bits;
	logic [drc_pkg::KeyW-1:0]        dom_mask;
	logic [drc_pkg::KeyW-1:0]        hi_clip;
	logic                            range_empty;
	logic [drc_pkg::HeightW-1:0]     root_height;
	logic [drc_pkg::KeyW-1:0]        span_mask;
	logic [drc_pkg::KeyW-1:0]        node_lo;
	logic [drc_pkg::KeyW-1:0]        node_hi;
	logic                            covered;
	logic                            overlap;
	logic                            split;
	logic [drc_pkg::KeyW-1:0]        child_base;
	logic [drc_pkg::HeightW-1:0]     child_height;

	always_comb begin
		if (active_bits == '0) begin
			eff_bits = drc_pkg::ActiveBitsW'(1);
		end else if (active_bits > drc_pkg::ActiveBitsW'(drc_pkg::MaxBits)) begin
			eff_bits = drc_pkg::ActiveBitsW'(drc_pkg::MaxBits);
		end else begin
			eff_bits = active_bits;
		end
	end

	assign dom_mask    = drc_pkg::KeyW'(({1'b0, {drc_pkg::KeyW{1'b0}}} | (33'd1 << eff_bits))
		- 33'd1);
	assign hi_clip     = (query.right_edge > dom_mask) ? dom_mask : query.right_edge;
	assign range_empty = (query.left_edge > hi_clip);
	assign root_height = drc_pkg::HeightW'(eff_bits - drc_pkg::ActiveBitsW'(1));

	assign span_mask    = (drc_pkg::KeyW'(1) << top_q.height) - drc_pkg::KeyW'(1);
	assign node_lo      = top_q.prefix << top_q.height;
	assign node_hi      = node_lo | span_mask;
	assign covered      = (lo_q <= node_lo) && (hi_q >= node_hi);
	assign overlap      = (node_lo <= hi_q) && (lo_q <= node_hi);
	assign split        = !covered && (top_q.height != '0) && overlap;
	assign child_base   = {top_q.prefix[drc_pkg::KeyW-2:0], 1'b0};
	assign child_height = top_q.height - drc_pkg::HeightW'(1);

	always_comb begin
		stack_req       = '0;
		stack_req.raddr = sp_q[drc_pkg::StackAw-1:0] - drc_pkg::StackAw'(1);
		case (state_q)
			ST_IDLE: begin
				stack_req.we           = start && !range_empty;
				stack_req.waddr        = '0;
				stack_req.wdata.prefix = '0;
				stack_req.wdata.height = root_height;
			end
			ST_WALK: begin
				stack_req.we           = split;
				stack_req.waddr        = sp_q[drc_pkg::StackAw-1:0];
				stack_req.wdata.prefix = child_base;
				stack_req.wdata.height = child_height;
			end
			default: begin
				stack_req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			top_q        <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			lo_q         <= '0;
			hi_q         <= '0;
			sp_q         <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						lo_q <= query.left_edge;
						hi_q <= hi_clip;
						if (range_empty) begin
							res_valid_q       <= 1'b1;
							res_q.node_prefix <= '0;
							res_q.node_height <= '0;
							res_q.is_empty    <= 1'b1;
							res_q.last        <= 1'b1;
						end else begin
							top_q.prefix <= drc_pkg::KeyW'(1);
							top_q.height <= root_height;
							sp_q         <= drc_pkg::SpW'(1);
							pend_valid_q <= 1'b0;
							state_q      <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (covered) begin
						if (pend_valid_q) begin
							res_valid_q       <= 1'b1;
							res_q.node_prefix <= pend_q.prefix;
							res_q.node_height <= pend_q.height;
							res_q.is_empty    <= 1'b0;
							res_q.last        <= 1'b0;
						end
						pend_q       <= top_q;
						pend_valid_q <= 1'b1;
					end
					if (split) begin
						sp_q         <= sp_q + drc_pkg::SpW'(1);
						top_q.prefix <= child_base | drc_pkg::KeyW'(1);
						top_q.height <= child_height;
					end else if (sp_q == '0) begin
						state_q <= ST_FLUSH;
					end else begin
						sp_q    <= sp_q - drc_pkg::SpW'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					top_q   <= stack_rdata;
					state_q <= ST_WALK;
				end
				ST_FLUSH: begin
					res_valid_q       <= 1'b1;
					res_q.node_prefix <= pend_q.prefix;
					res_q.node_height <= pend_q.height;
					res_q.is_empty    <= 1'b0;
					res_q.last        <= 1'b1;
					pend_valid_q      <= 1'b0;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

FILE: src/dyadic_range_cover_core.sv
// channel   direction  handshake                        transfer
// config    in         psel & penable & pwrite & pready register write, APB setup + access
// query     in         start & !busy                    one {left_edge, right_edge}
// result    out        result_valid, one cycle          one node; last marks the final one
//
// A query visits nodes depth-first, one node per cycle; a node taken back from the
// stack memory waits in a fetch state for the read, and a flush state follows the last node.
// busy is high while a query runs.
// An empty range gives its single result the cycle after start, and busy stays low.
// Reset sets active_bits to 32; the stack memory needs no clearing.
// The receiver cannot stall: each result shows for exactly one cycle.
module dyadic_range_cover_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [drc_pkg::CfgAw-1:0]    paddr,
	input  logic [drc_pkg::CfgDw-1:0]    pwdata,
	output logic [drc_pkg::CfgDw-1:0]    prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  drc_pkg::query_t              query,
	output logic                         result_valid,
	output drc_pkg::result_t             result
);

	logic [drc_pkg::ActiveBitsW-1:0] active_bits;
	drc_pkg::stack_req_t             stack_req;
	drc_pkg::node_t                  stack_rdata;

	drc_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.active_bits (active_bits)
	);

	drc_stack_ram u_stack (
		.clk   (clk),
		.req   (stack_req),
		.rdata (stack_rdata)
	);

	drc_walk u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.query        (query),
		.active_bits  (active_bits),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result),
		.stack_req    (stack_req),
		.stack_rdata  (stack_rdata)
	);

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_empty |-> result.last)
		else $error("empty-range result without last");

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_empty |->
			(result.node_prefix == '0) && (result.node_height == '0))
		else $error("empty-range result carries a node");

	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("non-final result while idle");

endmodule
